>>> hdl/bpf_pkg.sv
// ---------------------------------------------------------------------------
// Bezier path flattener package
// Shared types, command codes and fixed-point helpers.
// ---------------------------------------------------------------------------
package bpf_pkg;

    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MAX_DEPTH = 6;
    localparam int DEPTH_W   = 3;
    localparam int TOL_W     = 23;
    localparam int CMD_W     = 3;
    localparam int LIMB_W    = 25;
    localparam int PROD_W    = 2 * LIMB_W;
    localparam int ACC_W     = 104;

    // command codes
    localparam logic [CMD_W-1:0] CMD_MOVE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LINE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUAD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CUBIC = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd4;

    // configuration register indexes
    localparam logic CFG_TOL   = 1'b0;
    localparam logic CFG_DEPTH = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_pt;

    // one classified request handed from front to back
    typedef struct packed {
        logic curve;
        logic cubic;
        logic st;
        logic cl;
        logic er;
        t_pt  a;
        t_pt  c1;
        t_pt  c2;
        t_pt  b;
    } t_cmd;

    typedef struct packed {
        t_pt  pt;
        logic st;
        logic cl;
        logic er;
        logic last;
    } t_res;

    // midpoint, rounded toward minus infinity
    function automatic logic signed [COORD_W-1:0] mid1(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] q
    );
        logic signed [DIFF_W-1:0] s;
        s = {p[COORD_W-1], p} + {q[COORD_W-1], q};
        return s[DIFF_W-1:1];
    endfunction

    function automatic t_pt midp(input t_pt p, input t_pt q);
        t_pt r;
        r.x = mid1(p.x, q.x);
        r.y = mid1(p.y, q.y);
        return r;
    endfunction

    // magnitude of a coordinate difference
    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

endpackage

>>> hdl/bpf_front.sv
// ---------------------------------------------------------------------------
// Bezier path flattener front end
// Accepts path commands, tracks the current point and open contour, and
// classifies each command into a single result or a curve job.
// ---------------------------------------------------------------------------
module bpf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [2:0]             i_cmd,
    input  bpf_pkg::t_pt           i_c1,
    input  bpf_pkg::t_pt           i_c2,
    input  bpf_pkg::t_pt           i_end,
    input  logic                   i_qfull,
    output logic                   o_enq,
    output bpf_pkg::t_cmd          o_cmd
);
    import bpf_pkg::*;

    t_pt  r_cp;
    logic r_open;
    t_pt  n_cp;
    logic n_open;
    logic enq;
    logic accept;
    t_pt  zero_pt;

    assign accept  = i_push && !i_qfull;
    assign zero_pt = '0;

    // classify the request
    always_comb begin
        n_cp   = r_cp;
        n_open = r_open;
        enq    = 1'b0;
        o_cmd  = '0;
        o_cmd.a  = r_cp;
        o_cmd.c1 = i_c1;
        o_cmd.c2 = i_c2;
        o_cmd.b  = zero_pt;
        case (i_cmd)
            CMD_MOVE: begin
                enq      = 1'b1;
                o_cmd.b  = i_end;
                o_cmd.st = 1'b1;
                n_cp     = i_end;
                n_open   = 1'b1;
            end
            CMD_LINE: begin
                enq = 1'b1;
                if (!r_open) begin
                    o_cmd.er = 1'b1;
                end else begin
                    o_cmd.b = i_end;
                    n_cp    = i_end;
                end
            end
            CMD_CLOSE: begin
                enq = 1'b1;
                if (!r_open) begin
                    o_cmd.er = 1'b1;
                end else begin
                    o_cmd.cl = 1'b1;
                    n_open   = 1'b0;
                end
            end
            CMD_QUAD, CMD_CUBIC: begin
                enq = 1'b1;
                if (!r_open) begin
                    o_cmd.er = 1'b1;
                end else begin
                    o_cmd.curve = 1'b1;
                    o_cmd.cubic = (i_cmd == CMD_CUBIC);
                    o_cmd.b     = i_end;
                    n_cp        = i_end;
                end
            end
            default: begin
                enq = 1'b0;
            end
        endcase
    end

    assign o_enq = accept && enq;

    // hold path state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp   <= '0;
            r_open <= 1'b0;
        end else if (accept) begin
            r_cp   <= n_cp;
            r_open <= n_open;
        end
    end

endmodule

>>> hdl/bpf_cmdq.sv
// ---------------------------------------------------------------------------
// Bezier path flattener request queue
// Two-entry queue between front end and back end.
// ---------------------------------------------------------------------------
module bpf_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_enq,
    input  bpf_pkg::t_cmd i_data,
    input  logic          i_deq,
    output logic          o_full,
    output logic          o_empty,
    output bpf_pkg::t_cmd o_head
);
    import bpf_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_enq;
    logic       do_deq;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];
    assign do_enq  = i_enq && !o_full;
    assign do_deq  = i_deq && !o_empty;

    // store entries
    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_enq) r_wp <= ~r_wp;
            if (do_deq) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_enq} - {1'b0, do_deq};
        end
    end

endmodule

>>> hdl/bpf_chord.sv
// ---------------------------------------------------------------------------
// Bezier path flattener chord test
// Decides whether a control point lies within tolerance of a chord segment,
// using one shared 25x25 multiplier and a wide accumulator; each partial
// product is registered before it is accumulated.
// ---------------------------------------------------------------------------
module bpf_chord (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  bpf_pkg::t_pt                i_p,
    input  bpf_pkg::t_pt                i_a,
    input  bpf_pkg::t_pt                i_b,
    input  logic [bpf_pkg::TOL_W-1:0]   i_tol,
    output logic                        o_done,
    output logic                        o_flat
);
    import bpf_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_TOL  = 5'd1;
    localparam logic [4:0] S_L1   = 5'd2;
    localparam logic [4:0] S_L2   = 5'd3;
    localparam logic [4:0] S_CHKL = 5'd4;
    localparam logic [4:0] S_D1   = 5'd5;
    localparam logic [4:0] S_D2   = 5'd6;
    localparam logic [4:0] S_CHKD = 5'd7;
    localparam logic [4:0] S_C1   = 5'd8;
    localparam logic [4:0] S_C2   = 5'd9;
    localparam logic [4:0] S_CHKC = 5'd10;
    localparam logic [4:0] S_Q1   = 5'd11;
    localparam logic [4:0] S_Q2   = 5'd12;
    localparam logic [4:0] S_Q3   = 5'd13;
    localparam logic [4:0] S_Q4   = 5'd14;
    localparam logic [4:0] S_T1   = 5'd15;
    localparam logic [4:0] S_T2   = 5'd16;
    localparam logic [4:0] S_T3   = 5'd17;
    localparam logic [4:0] S_T4   = 5'd18;
    localparam logic [4:0] S_FINT = 5'd19;
    localparam logic [4:0] S_N1   = 5'd20;
    localparam logic [4:0] S_N2   = 5'd21;
    localparam logic [4:0] S_FINN = 5'd22;

    localparam int TOL2_W = 2 * TOL_W;
    localparam int LEN2_W = 2 * LIMB_W;

    logic [4:0]                     r_state;
    logic                           r_ph;
    logic [TOL_W-1:0]               r_tol;
    logic signed [DIFF_W-1:0]       r_lx, r_ly, r_ux, r_uy, r_vx, r_vy;
    logic                           r_usel;
    logic [PROD_W-1:0]              r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic [TOL2_W-1:0]              r_tol2;
    logic [LEN2_W-1:0]              r_len2;
    logic [LEN2_W-1:0]              r_c;
    logic                           r_done;
    logic                           r_flat;

    logic [LIMB_W-1:0]              opa, opb;
    logic                           neg, clr, is_mul;
    logic [1:0]                     sh;
    logic [4:0]                     succ;
    logic signed [DIFF_W-1:0]       wx, wy;
    logic [ACC_W-1:0]               term;
    logic signed [ACC_W-1:0]        n_acc;
    logic signed [ACC_W-1:0]        acc_abs;
    logic                           acc_le0;

    assign wx      = r_usel ? r_ux : r_vx;
    assign wy      = r_usel ? r_uy : r_vy;
    assign acc_le0 = r_acc[ACC_W-1] || (r_acc == '0);
    assign acc_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;

    // select multiplier operands for each step
    always_comb begin
        opa    = '0;
        opb    = '0;
        neg    = 1'b0;
        clr    = 1'b0;
        sh     = 2'd0;
        is_mul = 1'b1;
        succ   = S_IDLE;
        case (r_state)
            S_TOL: begin
                opa = LIMB_W'(r_tol); opb = LIMB_W'(r_tol); clr = 1'b1; succ = S_L1;
            end
            S_L1: begin
                opa = mag(r_lx); opb = mag(r_lx); clr = 1'b1; succ = S_L2;
            end
            S_L2: begin
                opa = mag(r_ly); opb = mag(r_ly); succ = S_CHKL;
            end
            S_D1: begin
                opa = mag(r_ux); opb = mag(r_lx); clr = 1'b1;
                neg = r_ux[DIFF_W-1] ^ r_lx[DIFF_W-1]; succ = S_D2;
            end
            S_D2: begin
                opa = mag(r_uy); opb = mag(r_ly);
                neg = r_uy[DIFF_W-1] ^ r_ly[DIFF_W-1]; succ = S_CHKD;
            end
            S_C1: begin
                opa = mag(r_ux); opb = mag(r_ly); clr = 1'b1;
                neg = r_ux[DIFF_W-1] ^ r_ly[DIFF_W-1]; succ = S_C2;
            end
            S_C2: begin
                opa = mag(r_uy); opb = mag(r_lx);
                neg = ~(r_uy[DIFF_W-1] ^ r_lx[DIFF_W-1]); succ = S_CHKC;
            end
            S_Q1: begin
                opa = r_c[LIMB_W-1:0]; opb = r_c[LIMB_W-1:0]; clr = 1'b1; succ = S_Q2;
            end
            S_Q2: begin
                opa = r_c[LIMB_W-1:0]; opb = r_c[LEN2_W-1:LIMB_W]; sh = 2'd1; succ = S_Q3;
            end
            S_Q3: begin
                opa = r_c[LIMB_W-1:0]; opb = r_c[LEN2_W-1:LIMB_W]; sh = 2'd1; succ = S_Q4;
            end
            S_Q4: begin
                opa = r_c[LEN2_W-1:LIMB_W]; opb = r_c[LEN2_W-1:LIMB_W]; sh = 2'd2;
                succ = S_T1;
            end
            S_T1: begin
                opa = r_tol2[LIMB_W-1:0]; opb = r_len2[LIMB_W-1:0]; neg = 1'b1;
                succ = S_T2;
            end
            S_T2: begin
                opa = r_tol2[LIMB_W-1:0]; opb = r_len2[LEN2_W-1:LIMB_W]; neg = 1'b1;
                sh = 2'd1; succ = S_T3;
            end
            S_T3: begin
                opa = LIMB_W'(r_tol2[TOL2_W-1:LIMB_W]); opb = r_len2[LIMB_W-1:0];
                neg = 1'b1; sh = 2'd1; succ = S_T4;
            end
            S_T4: begin
                opa = LIMB_W'(r_tol2[TOL2_W-1:LIMB_W]); opb = r_len2[LEN2_W-1:LIMB_W];
                neg = 1'b1; sh = 2'd2; succ = S_FINT;
            end
            S_N1: begin
                opa = mag(wx); opb = mag(wx); clr = 1'b1; succ = S_N2;
            end
            S_N2: begin
                opa = mag(wy); opb = mag(wy); succ = S_FINN;
            end
            default: begin
                is_mul = 1'b0;
            end
        endcase
    end

    // align and sign the registered product
    always_comb begin
        case (sh)
            2'd1:    term = ACC_W'(r_prod) << LIMB_W;
            2'd2:    term = ACC_W'(r_prod) << (2 * LIMB_W);
            default: term = ACC_W'(r_prod);
        endcase
        n_acc = (clr ? '0 : r_acc) + (neg ? -$signed(term) : $signed(term));
    end

    assign o_done = r_done;
    assign o_flat = r_flat;

    // step through the test
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_done  <= 1'b0;
            r_flat  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (is_mul) begin
                if (!r_ph) begin
                    r_ph   <= 1'b1;
                    r_prod <= PROD_W'(opa) * PROD_W'(opb);
                    if (r_state == S_L1) r_tol2 <= r_acc[TOL2_W-1:0];
                end else begin
                    r_ph    <= 1'b0;
                    r_acc   <= n_acc;
                    r_state <= succ;
                end
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (i_start) begin
                            r_tol   <= i_tol;
                            r_lx    <= {i_b.x[COORD_W-1], i_b.x} - {i_a.x[COORD_W-1], i_a.x};
                            r_ly    <= {i_b.y[COORD_W-1], i_b.y} - {i_a.y[COORD_W-1], i_a.y};
                            r_ux    <= {i_p.x[COORD_W-1], i_p.x} - {i_a.x[COORD_W-1], i_a.x};
                            r_uy    <= {i_p.y[COORD_W-1], i_p.y} - {i_a.y[COORD_W-1], i_a.y};
                            r_vx    <= {i_p.x[COORD_W-1], i_p.x} - {i_b.x[COORD_W-1], i_b.x};
                            r_vy    <= {i_p.y[COORD_W-1], i_p.y} - {i_b.y[COORD_W-1], i_b.y};
                            r_state <= S_TOL;
                        end
                    end
                    S_CHKL: begin
                        r_len2 <= r_acc[LEN2_W-1:0];
                        if (r_acc == '0) begin
                            r_usel  <= 1'b1;
                            r_state <= S_N1;
                        end else begin
                            r_state <= S_D1;
                        end
                    end
                    S_CHKD: begin
                        if (acc_le0) begin
                            r_usel  <= 1'b1;
                            r_state <= S_N1;
                        end else if (r_acc >= $signed(ACC_W'(r_len2))) begin
                            r_usel  <= 1'b0;
                            r_state <= S_N1;
                        end else begin
                            r_state <= S_C1;
                        end
                    end
                    S_CHKC: begin
                        r_c     <= acc_abs[LEN2_W-1:0];
                        r_state <= S_Q1;
                    end
                    S_FINT: begin
                        r_done  <= 1'b1;
                        r_flat  <= acc_le0;
                        r_state <= S_IDLE;
                    end
                    S_FINN: begin
                        r_done  <= 1'b1;
                        r_flat  <= (r_acc <= $signed(ACC_W'(r_tol2)));
                        r_state <= S_IDLE;
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

>>> hdl/bpf_back.sv
// ---------------------------------------------------------------------------
// Bezier path flattener back end
// Carries out queued requests: emits single results and subdivides curves
// depth first with a row stack, then buffers results in a two-entry queue.
// ---------------------------------------------------------------------------
module bpf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [bpf_pkg::TOL_W-1:0]   i_cfg_data,
    input  logic                        i_qempty,
    input  bpf_pkg::t_cmd               i_qhead,
    output logic                        o_qpop,
    input  logic                        i_opop,
    output logic                        o_oempty,
    output bpf_pkg::t_res               o_res
);
    import bpf_pkg::*;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_EMITC = 3'd1;
    localparam logic [2:0] B_HEAD  = 3'd2;
    localparam logic [2:0] B_W1    = 3'd3;
    localparam logic [2:0] B_T2    = 3'd4;
    localparam logic [2:0] B_W2    = 3'd5;
    localparam logic [2:0] B_SPLIT = 3'd6;
    localparam logic [2:0] B_EMIT  = 3'd7;

    typedef struct packed {
        t_pt c1;
        t_pt c2;
        t_pt b;
    } t_row;

    logic [TOL_W-1:0]   r_tol;
    logic [DEPTH_W-1:0] r_md;
    logic [2:0]         r_state;
    t_pt                r_a, r_c1, r_c2, r_b;
    logic               r_cubic, r_st, r_cl, r_er;
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] r_sl;
    t_row               r_stk [MAX_DEPTH];
    logic [DEPTH_W-1:0] r_lvl [MAX_DEPTH];

    t_res               r_ob [2];
    logic               r_owp, r_orp;
    logic [1:0]         r_ocnt;

    logic [DEPTH_W-1:0] md_sat;
    logic [DEPTH_W-1:0] sl_dn;
    logic               ch_start, ch_done, ch_flat;
    t_pt                ch_p;
    logic               ob_space, ob_push, ob_pop;
    t_res               ob_data;
    t_pt                a1, c12, c2b, lc, rc, mc;
    t_pt                ac, cb, mq;
    t_row               pop_row;
    t_pt                zero_pt;

    assign zero_pt  = '0;
    assign md_sat   = (r_md > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : r_md;
    assign sl_dn    = r_sl - 1'b1;
    assign pop_row  = r_stk[sl_dn];
    assign ob_space = (r_ocnt != 2'd2);
    assign ob_pop   = i_opop && (r_ocnt != 2'd0);
    assign o_oempty = (r_ocnt == 2'd0);
    assign o_res    = r_ob[r_orp];
    assign o_qpop   = (r_state == B_IDLE) && !i_qempty;

    // start a chord test on the first or second control point
    assign ch_start = ((r_state == B_HEAD) && (r_depth < md_sat)) || (r_state == B_T2);
    assign ch_p     = (r_state == B_T2) ? r_c2 : r_c1;

    bpf_chord u_chord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ch_start),
        .i_p     (ch_p),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_tol   (r_tol),
        .o_done  (ch_done),
        .o_flat  (ch_flat)
    );

    // de Casteljau halves
    assign a1  = midp(r_a, r_c1);
    assign c12 = midp(r_c1, r_c2);
    assign c2b = midp(r_c2, r_b);
    assign lc  = midp(a1, c12);
    assign rc  = midp(c12, c2b);
    assign mc  = midp(lc, rc);
    assign ac  = midp(r_a, r_c1);
    assign cb  = midp(r_c1, r_b);
    assign mq  = midp(ac, cb);

    // form the outgoing result
    always_comb begin
        ob_push = 1'b0;
        ob_data = '0;
        if (r_state == B_EMITC) begin
            ob_push      = ob_space;
            ob_data.pt   = r_b;
            ob_data.st   = r_st;
            ob_data.cl   = r_cl;
            ob_data.er   = r_er;
            ob_data.last = 1'b1;
        end else if (r_state == B_EMIT) begin
            ob_push      = ob_space;
            ob_data.pt   = r_b;
            ob_data.last = (r_sl == '0);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(64);
            r_md  <= DEPTH_W'(MAX_DEPTH);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOL:   r_tol <= i_cfg_data;
                CFG_DEPTH: r_md  <= i_cfg_data[DEPTH_W-1:0];
                default:   r_tol <= r_tol;
            endcase
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (ob_push) begin
            r_ob[r_owp] <= ob_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (ob_push) r_owp <= ~r_owp;
            if (ob_pop)  r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + {1'b0, ob_push} - {1'b0, ob_pop};
        end
    end

    // subdivision stack
    always_ff @(posedge i_clk) begin
        if (r_state == B_SPLIT) begin
            r_lvl[r_sl] <= r_depth + 1'b1;
            if (r_cubic) begin
                r_stk[r_sl] <= '{c1: rc, c2: c2b, b: r_b};
            end else begin
                r_stk[r_sl] <= '{c1: cb, c2: zero_pt, b: r_b};
            end
        end
    end

    // sequence the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_sl    <= '0;
            r_depth <= '0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (!i_qempty) begin
                        r_a     <= i_qhead.a;
                        r_c1    <= i_qhead.c1;
                        r_c2    <= i_qhead.c2;
                        r_b     <= i_qhead.b;
                        r_cubic <= i_qhead.cubic;
                        r_st    <= i_qhead.st;
                        r_cl    <= i_qhead.cl;
                        r_er    <= i_qhead.er;
                        r_depth <= '0;
                        r_sl    <= '0;
                        r_state <= i_qhead.curve ? B_HEAD : B_EMITC;
                    end
                end
                B_EMITC: begin
                    if (ob_space) r_state <= B_IDLE;
                end
                B_HEAD: begin
                    r_state <= (r_depth < md_sat) ? B_W1 : B_EMIT;
                end
                B_W1: begin
                    if (ch_done) begin
                        if (!ch_flat)     r_state <= B_SPLIT;
                        else if (r_cubic) r_state <= B_T2;
                        else              r_state <= B_EMIT;
                    end
                end
                B_T2: begin
                    r_state <= B_W2;
                end
                B_W2: begin
                    if (ch_done) r_state <= ch_flat ? B_EMIT : B_SPLIT;
                end
                B_SPLIT: begin
                    r_depth <= r_depth + 1'b1;
                    r_sl    <= r_sl + 1'b1;
                    if (r_cubic) begin
                        r_c1 <= a1;
                        r_c2 <= lc;
                        r_b  <= mc;
                    end else begin
                        r_c1 <= ac;
                        r_b  <= mq;
                    end
                    r_state <= B_HEAD;
                end
                B_EMIT: begin
                    if (ob_space) begin
                        r_a <= r_b;
                        if (r_sl == '0) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_sl    <= sl_dn;
                            r_c1    <= pop_row.c1;
                            r_c2    <= pop_row.c2;
                            r_b     <= pop_row.b;
                            r_depth <= r_lvl[sl_dn];
                            r_state <= B_HEAD;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/bezier_path_flattener_top.sv
// ---------------------------------------------------------------------------
// Bezier path flattener
// Flattens move, line, quadratic, cubic and close commands into polyline
// vertices with adaptive midpoint subdivision.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter through push/full: a command is taken at a clock edge
//   with push high and full low. Results leave through empty/pop: the
//   oldest result sits on o_point_x..o_last while empty is low and is
//   consumed when pop is high. o_last marks a command's final result.
//   With the back end idle, a move, line, close or error request passes
//   through the request queue and the back end's idle and emit states
//   before its one result shows. A curve piece takes at most one chord
//   test per control point in the shared 25x25 multiply-accumulate unit,
//   then a split or an emit. A two-entry request queue lets the front accept
//   commands while a curve is in work; a two-entry result queue lets the
//   back finish a result while the receiver stalls. When the request
//   queue fills, full rises and stays high until the back end takes one.
//   Configuration writes (tolerance, max_depth) are taken at once and must
//   only happen while the block is idle.
//   Reset clears the current point to the origin, closes the contour,
//   empties both queues and loads tolerance 64 and depth 6.
// ---------------------------------------------------------------------------
module bezier_path_flattener_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [bpf_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [bpf_pkg::COORD_W-1:0]  i_ctrl1_x,
    input  logic signed [bpf_pkg::COORD_W-1:0]  i_ctrl1_y,
    input  logic signed [bpf_pkg::COORD_W-1:0]  i_ctrl2_x,
    input  logic signed [bpf_pkg::COORD_W-1:0]  i_ctrl2_y,
    input  logic signed [bpf_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [bpf_pkg::COORD_W-1:0]  i_end_y,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [bpf_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [bpf_pkg::COORD_W-1:0]  o_point_y,
    output logic                                o_starts_contour,
    output logic                                o_closes_contour,
    output logic                                o_error,
    output logic                                o_last,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [bpf_pkg::TOL_W-1:0]           i_cfg_data
);
    import bpf_pkg::*;

    t_pt  c1, c2, e;
    t_cmd f_cmd, q_head;
    logic f_enq, q_full, q_empty, q_pop;
    t_res res;

    assign c1 = '{x: i_ctrl1_x, y: i_ctrl1_y};
    assign c2 = '{x: i_ctrl2_x, y: i_ctrl2_y};
    assign e  = '{x: i_end_x,   y: i_end_y};

    assign full = q_full;

    bpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (i_cmd),
        .i_c1    (c1),
        .i_c2    (c2),
        .i_end   (e),
        .i_qfull (q_full),
        .o_enq   (f_enq),
        .o_cmd   (f_cmd)
    );

    bpf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (f_enq),
        .i_data  (f_cmd),
        .i_deq   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    bpf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_qempty   (q_empty),
        .i_qhead    (q_head),
        .o_qpop     (q_pop),
        .i_opop     (pop),
        .o_oempty   (empty),
        .o_res      (res)
    );

    // drive result ports
    assign o_point_x        = res.pt.x;
    assign o_point_y        = res.pt.y;
    assign o_starts_contour = res.st;
    assign o_closes_contour = res.cl;
    assign o_error          = res.er;
    assign o_last           = res.last;

endmodule

>>> test/tb_bezier_path_flattener_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bezier path flattener testbench
// Drives path commands through the push/full port and compares every vertex
// popped from the result queue with a behavioral model of the flattener or a
// directed expected vertex, over several tolerance and depth settings and idle/stall patterns.
// ---------------------------------------------------------------------------
module tb_bezier_path_flattener_top;
    import bpf_pkg::*;

    localparam int LIMIT_CYCLES = 20000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;
    localparam int SMALL_SPAN = 4096;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic st;
        logic cl;
        logic er;
        logic last;
    } t_vertex;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        t_pt     c1;
        t_pt     c2;
        t_pt     e;
        logic    typed;
        t_vertex want;
    } t_path_row;

    logic i_clk, i_rst_n;
    logic push, full, empty, pop;
    logic [CMD_W-1:0] i_cmd;
    logic signed [COORD_W-1:0] i_ctrl1_x, i_ctrl1_y, i_ctrl2_x, i_ctrl2_y, i_end_x, i_end_y;
    logic signed [COORD_W-1:0] o_point_x, o_point_y;
    logic o_starts_contour, o_closes_contour, o_error, o_last;
    logic i_cfg_we, i_cfg_idx;
    logic [TOL_W-1:0] i_cfg_data;

    // model state
    t_pt cur_pt;
    logic contour_on;
    logic [TOL_W-1:0] tol_reg;
    logic [DEPTH_W-1:0] depth_reg;

    t_vertex vertex_q[$];
    t_path_row rows[$];
    int fail_cnt = 0, item_cnt = 0, vertex_cnt = 0, curve_cnt = 0, cycle_cnt = 0;
    int send_idle_pct = 0, recv_idle_pct = 0, hold_cnt = 0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;

    bezier_path_flattener_top DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // guard against a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---- model -----------------------------------------------------------
    function automatic logic signed [COORD_W-1:0] halfsum(longint p, longint q);
        longint s;
        s = p + q;
        return COORD_W'(s >>> 1);
    endfunction

    function automatic t_pt midpt(t_pt p, t_pt q);
        t_pt r;
        r.x = halfsum(p.x, q.x);
        r.y = halfsum(p.y, q.y);
        return r;
    endfunction

    function automatic logic close_to(longint dx, longint dy, logic [127:0] tol2);
        logic [127:0] d;
        d = 128'(dx * dx) + 128'(dy * dy);
        return d <= tol2;
    endfunction

    // control point within tolerance of segment a-b (projection clamped)
    function automatic logic near_chord(t_pt p, t_pt a, t_pt b);
        longint lx, ly, ux, uy, dotp, len2, crs;
        logic [127:0] tol2;
        lx = longint'(b.x) - a.x;
        ly = longint'(b.y) - a.y;
        ux = longint'(p.x) - a.x;
        uy = longint'(p.y) - a.y;
        tol2 = 128'(tol_reg) * 128'(tol_reg);
        len2 = lx * lx + ly * ly;
        if (len2 == 0) return close_to(ux, uy, tol2);
        dotp = ux * lx + uy * ly;
        if (dotp <= 0) return close_to(ux, uy, tol2);
        if (dotp >= len2) return close_to(longint'(p.x) - b.x, longint'(p.y) - b.y, tol2);
        crs = ux * ly - uy * lx;
        if (crs < 0) crs = -crs;
        return 128'(crs) * 128'(crs) <= tol2 * 128'(len2);
    endfunction

    function automatic t_vertex mk_vertex(t_pt p, logic st, logic cl, logic er, logic ls);
        t_vertex v;
        v.x = p.x; v.y = p.y; v.st = st; v.cl = cl; v.er = er; v.last = ls;
        return v;
    endfunction

    // subdivide a curve depth first, appending its vertices
    task automatic flatten_curve(t_pt c1, t_pt c2, t_pt b, logic cubic, ref t_vertex out[$]);
        t_pt a, s_c1[MAX_DEPTH], s_c2[MAX_DEPTH], s_b[MAX_DEPTH];
        t_pt a1, c12, c2b, lc, rc, zp;
        int s_d[MAX_DEPTH];
        int md, depth, lvl;
        logic flat;
        md = (depth_reg > MAX_DEPTH) ? MAX_DEPTH : depth_reg;
        depth = 0;
        lvl = 0;
        a = cur_pt;
        zp = '0;
        forever begin
            flat = depth >= md || (near_chord(c1, a, b) && (!cubic || near_chord(c2, a, b)));
            if (flat || lvl >= MAX_DEPTH) begin
                out.insert(out.size(), mk_vertex(b, 1'b0, 1'b0, 1'b0, 1'b0));
                a = b;
                if (lvl == 0) break;
                lvl--;
                c1 = s_c1[lvl]; c2 = s_c2[lvl]; b = s_b[lvl]; depth = s_d[lvl];
                continue;
            end
            depth++;
            if (cubic) begin
                a1 = midpt(a, c1); c12 = midpt(c1, c2); c2b = midpt(c2, b);
                lc = midpt(a1, c12); rc = midpt(c12, c2b);
                s_c1[lvl] = rc; s_c2[lvl] = c2b; s_b[lvl] = b;
                c1 = a1; c2 = lc; b = midpt(lc, rc);
            end else begin
                a1 = midpt(a, c1); c2b = midpt(c1, b);
                s_c1[lvl] = c2b; s_c2[lvl] = zp; s_b[lvl] = b;
                c1 = a1; b = midpt(a1, c2b);
            end
            s_d[lvl] = depth;
            lvl++;
        end
        out[out.size()-1].last = 1'b1;
    endtask

    task automatic predict_path(t_path_row r, ref t_vertex out[$]);
        t_pt zp;
        zp = '0;
        if (r.cmd > CMD_CLOSE) return;
        if (r.cmd == CMD_MOVE) begin
            cur_pt = r.e;
            contour_on = 1'b1;
            out.insert(out.size(), mk_vertex(r.e, 1'b1, 1'b0, 1'b0, 1'b1));
        end else if (!contour_on) begin
            out.insert(out.size(), mk_vertex(zp, 1'b0, 1'b0, 1'b1, 1'b1));
        end else if (r.cmd == CMD_LINE) begin
            cur_pt = r.e;
            out.insert(out.size(), mk_vertex(r.e, 1'b0, 1'b0, 1'b0, 1'b1));
        end else if (r.cmd == CMD_CLOSE) begin
            contour_on = 1'b0;
            out.insert(out.size(), mk_vertex(zp, 1'b0, 1'b1, 1'b0, 1'b1));
        end else begin
            curve_cnt++;
            flatten_curve(r.c1, r.c2, r.e, r.cmd == CMD_CUBIC, out);
            cur_pt = r.e;
        end
    endtask

    // ---- request side ----------------------------------------------------
    task automatic send_path(t_path_row r);
        t_vertex got[$];
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push = 1'b1;
        i_cmd = r.cmd;
        i_ctrl1_x = r.c1.x; i_ctrl1_y = r.c1.y;
        i_ctrl2_x = r.c2.x; i_ctrl2_y = r.c2.y;
        i_end_x = r.e.x; i_end_y = r.e.y;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        item_cnt++;
        predict_path(r, got);
        if (r.typed && got.size() != 0) vertex_q.insert(vertex_q.size(), r.want);
        else foreach (got[k]) vertex_q.insert(vertex_q.size(), got[k]);
    endtask

    task automatic idle_push();
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [TOL_W-1:0] val);
        idle_push();
        wait (vertex_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_TOL) tol_reg = val;
        else depth_reg = val[DEPTH_W-1:0];
    endtask

    function automatic t_pt xy(longint x, longint y);
        t_pt p;
        p.x = COORD_W'(x); p.y = COORD_W'(y);
        return p;
    endfunction

    function automatic t_path_row mk_row(logic [CMD_W-1:0] c, t_pt c1, t_pt c2, t_pt e);
        t_path_row r;
        r.cmd = c; r.c1 = c1; r.c2 = c2; r.e = e; r.typed = 1'b0; r.want = '{default: 0};
        return r;
    endfunction

    function automatic t_path_row typed_row(logic [CMD_W-1:0] c, t_pt e, t_vertex v);
        t_path_row r;
        r = mk_row(c, xy(0, 0), xy(0, 0), e);
        r.typed = 1'b1;
        r.want = v;
        return r;
    endfunction

    // random point: mostly near a base, sometimes anywhere in range
    function automatic t_pt rnd_pt(t_pt base, int span);
        if ($urandom_range(99) < 6) return xy($signed(COORD_W'($urandom)), $signed(COORD_W'($urandom)));
        return xy(longint'(base.x) + $signed($urandom_range(2 * span)) - span,
                  longint'(base.y) + $signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic t_path_row rnd_noise();
        logic [CMD_W-1:0] c;
        c = CMD_W'($urandom_range(CMD_RSVD_LAST));
        return mk_row(c, xy($signed(COORD_W'($urandom)), $signed(COORD_W'($urandom))),
                      xy($signed(COORD_W'($urandom)), $signed(COORD_W'($urandom))),
                      xy($signed(COORD_W'($urandom)), $signed(COORD_W'($urandom))));
    endfunction

    // one well-formed contour with random content, or a noise request
    task automatic send_random(ref int left);
        t_pt p;
        int span, segs;
        logic [CMD_W-1:0] c;
        if ($urandom_range(99) < 15) begin
            send_path(rnd_noise());
            left--;
            return;
        end
        span = ($urandom_range(3) == 0) ? SMALL_SPAN * 16 : SMALL_SPAN;
        p = rnd_pt(xy(0, 0), 1 << 20);
        send_path(mk_row(CMD_MOVE, p, p, p));
        left--;
        segs = $urandom_range(1, 5);
        repeat (segs) begin
            c = CMD_W'($urandom_range(CMD_LINE, CMD_CUBIC));
            send_path(mk_row(c, rnd_pt(p, span), rnd_pt(p, span), rnd_pt(p, span)));
            p = cur_pt;
            left--;
        end
        if ($urandom_range(3) != 0) begin
            send_path(mk_row(CMD_CLOSE, p, p, p));
            left--;
        end
    endtask

    // ---- result side -----------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            pop = 1'b0;
        end else begin
            pop = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each popped vertex with the oldest prediction
    always @(posedge i_clk) begin
        t_vertex w;
        if (i_rst_n && pop && !empty) begin
            vertex_cnt++;
            if (vertex_q.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected result x=%0d y=%0d", $time, o_point_x, o_point_y);
            end else begin
                w = vertex_q.pop_front();
                if (o_point_x !== w.x || o_point_y !== w.y || o_starts_contour !== w.st ||
                    o_closes_contour !== w.cl || o_error !== w.er || o_last !== w.last) begin
                    fail_cnt++;
                    $display("%0t: expected x=%0d y=%0d st=%b cl=%b er=%b last=%b", $time,
                             w.x, w.y, w.st, w.cl, w.er, w.last);
                    $display("%0t:   actual x=%0d y=%0d st=%b cl=%b er=%b last=%b", $time,
                             o_point_x, o_point_y, o_starts_contour, o_closes_contour,
                             o_error, o_last);
                end
            end
        end
    end

    // ---- main sequence ---------------------------------------------------
    initial begin
        int left, ph;
        t_pt zp, pmax, pmin;
        zp = xy(0, 0);
        pmax = xy(8388607, 8388607);
        pmin = xy(-8388608, -8388608);
        push = 1'b0; pop = 1'b0; i_cmd = CMD_MOVE;
        i_ctrl1_x = '0; i_ctrl1_y = '0; i_ctrl2_x = '0; i_ctrl2_y = '0;
        i_end_x = '0; i_end_y = '0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_TOL; i_cfg_data = '0;
        cur_pt = zp; contour_on = 1'b0; tol_reg = 64; depth_reg = 6;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: no contour after reset, ignored codes, extremes, clamping
        rows.insert(rows.size(), typed_row(CMD_LINE, pmax, mk_vertex(zp, 0, 0, 1, 1)));
        rows.insert(rows.size(), typed_row(CMD_CLOSE, zp, mk_vertex(zp, 0, 0, 1, 1)));
        rows.insert(rows.size(), mk_row(CMD_QUAD, pmax, pmin, pmax));
        rows.insert(rows.size(), mk_row(CMD_CUBIC, pmin, pmax, pmin));
        rows.insert(rows.size(), mk_row(CMD_RSVD_FIRST, pmax, pmax, pmax));
        rows.insert(rows.size(), mk_row(CMD_RSVD_LAST, pmin, pmin, pmin));
        rows.insert(rows.size(), typed_row(CMD_MOVE, xy(8388607, -8388608),
                                 mk_vertex(xy(8388607, -8388608), 1, 0, 0, 1)));
        rows.insert(rows.size(), typed_row(CMD_LINE, xy(-8388608, 8388607),
                                 mk_vertex(xy(-8388608, 8388607), 0, 0, 0, 1)));
        rows.insert(rows.size(), mk_row(CMD_QUAD, pmax, zp, pmin));
        rows.insert(rows.size(), mk_row(CMD_CUBIC, pmin, pmax, xy(8388607, -8388608)));
        rows.insert(rows.size(), typed_row(CMD_MOVE, zp, mk_vertex(zp, 1, 0, 0, 1)));
        rows.insert(rows.size(), mk_row(CMD_QUAD, zp, zp, zp));
        rows.insert(rows.size(), mk_row(CMD_CUBIC, zp, zp, zp));
        rows.insert(rows.size(), mk_row(CMD_QUAD, xy(-3000, 0), zp, xy(1000, 0)));
        rows.insert(rows.size(), mk_row(CMD_CUBIC, xy(5000, 100), xy(-2000, -100),
                                        xy(2000, 0)));
        rows.insert(rows.size(), mk_row(CMD_QUAD, xy(100, 700), zp, xy(0, 0)));
        rows.insert(rows.size(), mk_row(CMD_CUBIC, xy(-1, 1), xy(-3, 5), xy(-7, -9)));
        rows.insert(rows.size(), typed_row(CMD_CLOSE, pmax, mk_vertex(zp, 0, 1, 0, 1)));
        rows.insert(rows.size(), typed_row(CMD_CLOSE, zp, mk_vertex(zp, 0, 0, 1, 1)));
        rows.insert(rows.size(), typed_row(CMD_MOVE, xy(12, -34),
                                           mk_vertex(xy(12, -34), 1, 0, 0, 1)));
        rows.insert(rows.size(), typed_row(CMD_MOVE, pmin, mk_vertex(pmin, 1, 0, 0, 1)));
        rows.insert(rows.size(), mk_row(CMD_CUBIC, xy(-8388000, 5000), xy(-3000, -8388000),
                                        zp));
        foreach (rows[k]) send_path(rows[k]);

        // register extremes, including zero depth, depth above the cap, zero tolerance
        write_reg(CFG_DEPTH, 0);
        send_path(mk_row(CMD_CUBIC, pmax, pmin, xy(100, 100)));
        write_reg(CFG_DEPTH, 7);
        write_reg(CFG_TOL, 0);
        send_path(mk_row(CMD_QUAD, xy(300, 300), zp, xy(600, 600)));
        send_path(mk_row(CMD_QUAD, xy(0, 9000), zp, xy(-4000, 0)));
        write_reg(CFG_TOL, 8388607);
        send_path(mk_row(CMD_CUBIC, pmin, pmax, xy(5, 5)));

        // random phases: receiver idles, sender idles, then full rate
        left = 380;
        for (ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin send_idle_pct = 23; recv_idle_pct = 67; end
                1: begin send_idle_pct = 67; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_reg(CFG_TOL, (ph == 5) ? TOL_W'(1) : TOL_W'($urandom_range(1, 2000)));
            write_reg(CFG_DEPTH, (ph == 4) ? DEPTH_W'(1) : DEPTH_W'($urandom_range(1, MAX_DEPTH)));
            if (ph == 2) hold_req = 1'b1;
            while (left > 380 - (ph + 1) * 64 && left > 0) send_random(left);
            if (ph == 2) begin
                idle_push();
                wait (vertex_q.size() == 0);
            end
        end
        while (left > 0) send_random(left);

        idle_push();
        wait (vertex_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d path requests (%0d curves), checked %0d vertices", item_cnt,
                 curve_cnt, vertex_cnt);
        $display("Covered no-contour errors, extremes, depth 0..7, tolerance 0..max, stalls");
        if (fail_cnt == 0 && vertex_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/bpf_pkg.sv
hdl/bpf_front.sv
hdl/bpf_cmdq.sv
hdl/bpf_chord.sv
hdl/bpf_back.sv
hdl/bezier_path_flattener_top.sv
test/tb_bezier_path_flattener_top.sv
